### src/assert_macros.svh
// Assertion macros shared by the blit address generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### src/cbag_pkg.sv
// Shared constants, codes and width helpers of the blit address generator.
package cbag_pkg;

   localparam int MAX_DIM_DEF = 4096;
   localparam int QUEUE_DEPTH = 8;

   typedef enum logic {
      KIND_START   = 1'b0,
      KIND_ADVANCE = 1'b1
   } kind_type;

   // size and position fields: one bit wider than $clog2 of the largest size
   function automatic int dim_width(input int max_dim);
      return $clog2(max_dim) + 1;
   endfunction

   function automatic int off_width(input int max_dim);
      return 2 * $clog2(max_dim);
   endfunction

   // command word passed from front to back
   function automatic int cmd_width(input int max_dim);
      return 3 + 4 * dim_width(max_dim) + 2 * off_width(max_dim);
   endfunction

endpackage

### src/cbag_front.sv
// Front end: accepts items, clips start commands and forms row start offsets.
module cbag_front import cbag_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             req_kind,
   input  logic [dim_width(MAX_DIM)-1:0]    req_dest_width,
   input  logic [dim_width(MAX_DIM)-1:0]    req_dest_height,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_dest_x,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_dest_y,
   input  logic [dim_width(MAX_DIM)-1:0]    req_rect_width,
   input  logic [dim_width(MAX_DIM)-1:0]    req_rect_height,
   input  logic [dim_width(MAX_DIM)-1:0]    req_src_width,
   input  logic [dim_width(MAX_DIM)-1:0]    req_src_height,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_src_x,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_src_y,
   input  logic                             req_dest_before_src,
   output logic                             push,
   output logic [cmd_width(MAX_DIM)-1:0]    push_data,
   output logic [1:0]                       inflight
);

   localparam int DW = dim_width(MAX_DIM);
   localparam int OW = off_width(MAX_DIM);
   localparam int CW = DW + 4;
   localparam logic signed [CW-1:0] ZERO = '0;
   localparam logic signed [CW-1:0] ONE  = CW'(1);

   typedef struct packed {
      logic signed [CW-1:0] s0;
      logic signed [CW-1:0] s1;
      logic signed [CW-1:0] d0;
      logic signed [CW-1:0] d1;
   } axis_type;

   typedef struct packed {
      logic          is_start;
      logic          empty;
      logic          descending;
      logic [DW-1:0] width;
      logic [DW-1:0] height;
      logic [DW-1:0] src_stride;
      logic [DW-1:0] dest_stride;
      logic [OW-1:0] src_start;
      logic [OW-1:0] dest_start;
   } cmd_type;

   function automatic logic signed [CW-1:0] sext(input logic [DW-1:0] v);
      return {{(CW-DW){v[DW-1]}}, v};
   endfunction

   function automatic logic signed [CW-1:0] zext(input logic [DW-1:0] v);
      return {{(CW-DW){1'b0}}, v};
   endfunction

   // cut against the source surface, move the destination corners alike
   function automatic axis_type cut_src(input axis_type a, input logic signed [CW-1:0] lim);
      axis_type r;
      r = a;
      if (r.s0 < ZERO) begin
         r.d0 = r.d0 - r.s0;
         r.s0 = ZERO;
      end
      if (r.s1 >= lim) begin
         r.d1 = r.d1 - (r.s1 - lim + ONE);
         r.s1 = lim - ONE;
      end
      return r;
   endfunction

   function automatic axis_type cut_dst(input axis_type a, input logic signed [CW-1:0] lim);
      axis_type r;
      r = a;
      if (r.d0 < ZERO) begin
         r.s0 = r.s0 - r.d0;
         r.d0 = ZERO;
      end
      if (r.d1 >= lim) begin
         r.s1 = r.s1 - (r.d1 - lim + ONE);
         r.d1 = lim - ONE;
      end
      return r;
   endfunction

   function automatic logic axis_empty(input axis_type a, input logic signed [CW-1:0] slim,
                                       input logic signed [CW-1:0] dlim);
      return (a.s1 < ZERO) || (a.s0 >= slim) || (a.d1 < ZERO) || (a.d0 >= dlim) ||
             (a.s1 < a.s0);
   endfunction

   // stage 1: source clip
   logic                 v1_ff, start1_ff, asc1_ff, zero1_ff;
   axis_type             x1_ff, y1_ff, x1_in, y1_in;
   logic signed [CW-1:0] sw1_ff, sh1_ff, dw1_ff, dh1_ff;
   axis_type             xr, yr;

   always_comb begin
      xr.s0 = sext(req_src_x);
      xr.d0 = sext(req_dest_x);
      xr.s1 = xr.s0 + zext(req_rect_width) - ONE;
      xr.d1 = xr.d0 + zext(req_rect_width) - ONE;
      yr.s0 = sext(req_src_y);
      yr.d0 = sext(req_dest_y);
      yr.s1 = yr.s0 + zext(req_rect_height) - ONE;
      yr.d1 = yr.d0 + zext(req_rect_height) - ONE;
      x1_in = cut_src(xr, zext(req_src_width));
      y1_in = cut_src(yr, zext(req_src_height));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      start1_ff <= (req_kind == KIND_START);
      asc1_ff   <= req_dest_before_src;
      zero1_ff  <= (req_rect_width == '0) || (req_rect_height == '0);
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      sw1_ff    <= zext(req_src_width);
      sh1_ff    <= zext(req_src_height);
      dw1_ff    <= zext(req_dest_width);
      dh1_ff    <= zext(req_dest_height);
   end

   // stage 2: destination clip, emptiness, corner selection
   axis_type      xd, yd;
   logic          empty2_in;
   logic          v2_ff, start2_ff, empty2_ff, desc2_ff;
   logic [DW-1:0] w2_ff, h2_ff, srow2_ff, scol2_ff, drow2_ff, dcol2_ff, sw2_ff, dw2_ff;

   always_comb begin
      xd = cut_dst(x1_ff, dw1_ff);
      yd = cut_dst(y1_ff, dh1_ff);
      empty2_in = zero1_ff || axis_empty(xd, sw1_ff, dw1_ff) ||
                  axis_empty(yd, sh1_ff, dh1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      start2_ff <= start1_ff;
      empty2_ff <= empty2_in;
      desc2_ff  <= !asc1_ff;
      w2_ff     <= DW'(xd.s1 - xd.s0 + ONE);
      h2_ff     <= DW'(yd.s1 - yd.s0 + ONE);
      srow2_ff  <= asc1_ff ? DW'(yd.s0) : DW'(yd.s1);
      scol2_ff  <= asc1_ff ? DW'(xd.s0) : DW'(xd.s1);
      drow2_ff  <= asc1_ff ? DW'(yd.d0) : DW'(yd.d1);
      dcol2_ff  <= asc1_ff ? DW'(xd.d0) : DW'(xd.d1);
      sw2_ff    <= DW'(sw1_ff);
      dw2_ff    <= DW'(dw1_ff);
   end

   // stage 3: row times stride
   logic [2*DW-1:0] sprod, dprod;
   logic            v3_ff, start3_ff, empty3_ff, desc3_ff;
   logic [OW-1:0]   sprod3_ff, dprod3_ff;
   logic [DW-1:0]   w3_ff, h3_ff, scol3_ff, dcol3_ff, sw3_ff, dw3_ff;

   assign sprod = srow2_ff * sw2_ff;
   assign dprod = drow2_ff * dw2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      start3_ff <= start2_ff;
      empty3_ff <= empty2_ff;
      desc3_ff  <= desc2_ff;
      sprod3_ff <= sprod[OW-1:0];
      dprod3_ff <= dprod[OW-1:0];
      w3_ff     <= w2_ff;
      h3_ff     <= h2_ff;
      scol3_ff  <= scol2_ff;
      dcol3_ff  <= dcol2_ff;
      sw3_ff    <= sw2_ff;
      dw3_ff    <= dw2_ff;
   end

   cmd_type cmd;

   always_comb begin
      cmd.is_start    = start3_ff;
      cmd.empty       = empty3_ff;
      cmd.descending  = desc3_ff;
      cmd.width       = w3_ff;
      cmd.height      = h3_ff;
      cmd.src_stride  = sw3_ff;
      cmd.dest_stride = dw3_ff;
      cmd.src_start   = sprod3_ff + OW'(scol3_ff);
      cmd.dest_start  = dprod3_ff + OW'(dcol3_ff);
   end

   assign push      = v3_ff;
   assign push_data = cmd;
   assign inflight  = 2'({1'b0, v1_ff} + {1'b0, v2_ff} + {1'b0, v3_ff});

endmodule

### src/cbag_queue.sv
// Command queue between the front end and the pixel sequencer.
`include "assert_macros.svh"
module cbag_queue import cbag_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       not_empty,
   output logic [WIDTH-1:0]           head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      // wrap at the last slot so any depth works
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = NW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = NW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push && !pop, count_ff != NW'(DEPTH))
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, count_ff != '0)

endmodule

### src/cbag_back.sv
// Back end: holds the run state and steps out one offset pair per advance beat.
`include "assert_macros.svh"
module cbag_back import cbag_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [cmd_width(MAX_DIM)-1:0] q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pixel_valid,
   output logic [off_width(MAX_DIM)-1:0] rsp_src_offset,
   output logic [off_width(MAX_DIM)-1:0] rsp_dest_offset,
   output logic                          rsp_last,
   output logic                          rsp_empty_res,
   output logic [dim_width(MAX_DIM)-1:0] rsp_clipped_width,
   output logic [dim_width(MAX_DIM)-1:0] rsp_clipped_height
);

   localparam int DW = dim_width(MAX_DIM);
   localparam int OW = off_width(MAX_DIM);

   typedef struct packed {
      logic          is_start;
      logic          empty;
      logic          descending;
      logic [DW-1:0] width;
      logic [DW-1:0] height;
      logic [DW-1:0] src_stride;
      logic [DW-1:0] dest_stride;
      logic [OW-1:0] src_start;
      logic [OW-1:0] dest_start;
   } cmd_type;

   cmd_type cmd;
   assign cmd = cmd_type'(q_data);

   logic          run_active_ff, run_active_in, desc_ff, desc_in;
   logic [OW-1:0] src_row_ff, src_row_in, dest_row_ff, dest_row_in;
   logic [DW-1:0] col_ff, col_in, rows_ff, rows_in, width_ff, width_in;
   logic [DW-1:0] sstr_ff, sstr_in, dstr_ff, dstr_in;

   logic          rsp_valid_ff, rsp_valid_in, pix_ff, pix_in, last_ff, last_in;
   logic          empty_ff, empty_in;
   logic [OW-1:0] soff_ff, soff_in, doff_ff, doff_in;
   logic [DW-1:0] cw_ff, cw_in, ch_ff, ch_in;

   logic          row_end, fin, pop;

   assign pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign row_end = ({1'b0, col_ff} + 1'b1) >= {1'b0, width_ff};
   assign fin     = row_end && (rows_ff <= DW'(1));

   always_comb begin
      run_active_in = run_active_ff;
      desc_in       = desc_ff;
      src_row_in    = src_row_ff;
      dest_row_in   = dest_row_ff;
      col_in        = col_ff;
      rows_in       = rows_ff;
      width_in      = width_ff;
      sstr_in       = sstr_ff;
      dstr_in       = dstr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pix_in        = pix_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      soff_in       = soff_ff;
      doff_in       = doff_ff;
      cw_in         = cw_ff;
      ch_in         = ch_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         pix_in       = 1'b0;
         last_in      = 1'b0;
         empty_in     = 1'b0;
         soff_in      = '0;
         doff_in      = '0;
         cw_in        = '0;
         ch_in        = '0;
         if (cmd.is_start) begin
            // a new command drops any run in progress
            run_active_in = !cmd.empty;
            empty_in      = cmd.empty;
            if (!cmd.empty) begin
               cw_in       = cmd.width;
               ch_in       = cmd.height;
               desc_in     = cmd.descending;
               src_row_in  = cmd.src_start;
               dest_row_in = cmd.dest_start;
               col_in      = '0;
               rows_in     = cmd.height;
               width_in    = cmd.width;
               sstr_in     = cmd.src_stride;
               dstr_in     = cmd.dest_stride;
            end
         end else if (run_active_ff) begin
            pix_in  = 1'b1;
            last_in = fin;
            if (desc_ff) begin
               soff_in = src_row_ff - OW'(col_ff);
               doff_in = dest_row_ff - OW'(col_ff);
            end else begin
               soff_in = src_row_ff + OW'(col_ff);
               doff_in = dest_row_ff + OW'(col_ff);
            end
            if (fin) begin
               run_active_in = 1'b0;
               col_in        = '0;
               rows_in       = '0;
            end else if (row_end) begin
               // step to the next row
               col_in  = '0;
               rows_in = DW'(rows_ff - 1'b1);
               if (desc_ff) begin
                  src_row_in  = src_row_ff - OW'(sstr_ff);
                  dest_row_in = dest_row_ff - OW'(dstr_ff);
               end else begin
                  src_row_in  = src_row_ff + OW'(sstr_ff);
                  dest_row_in = dest_row_ff + OW'(dstr_ff);
               end
            end else begin
               col_in = DW'(col_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         desc_ff       <= 1'b0;
         col_ff        <= '0;
         rows_ff       <= '0;
         width_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         desc_ff       <= desc_in;
         col_ff        <= col_in;
         rows_ff       <= rows_in;
         width_ff      <= width_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      src_row_ff  <= src_row_in;
      dest_row_ff <= dest_row_in;
      sstr_ff     <= sstr_in;
      dstr_ff     <= dstr_in;
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
      soff_ff     <= soff_in;
      doff_ff     <= doff_in;
      cw_ff       <= cw_in;
      ch_ff       <= ch_in;
   end

   assign q_pop              = pop;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_valid    = pix_ff;
   assign rsp_src_offset     = soff_ff;
   assign rsp_dest_offset    = doff_ff;
   assign rsp_last           = last_ff;
   assign rsp_empty_res      = empty_ff;
   assign rsp_clipped_width  = cw_ff;
   assign rsp_clipped_height = ch_ff;

   `ASSERT_IMPLIES(a_last_has_pixel, clock, reset, rsp_valid_ff && last_ff, pix_ff)
   `ASSERT_NEXT(a_fin_ends_run, clock, reset, pop && !cmd.is_start && run_active_ff && fin, !run_active_ff)

endmodule

### src/clipped_blit_address_generator_unit.sv
// Top level of the clipped blit address generator.
// Usage:
//   The req_ channel takes one item per beat. A start beat (req_kind = 0) carries
//   both surface sizes, both corners, the rectangle size and the order flag; its
//   result reports the clipped width and height, or rsp_empty_res when nothing is
//   left. Each advance beat (req_kind = 1) yields one source/destination offset
//   pair on the rsp_ channel; the final pair of the run has rsp_last set. An
//   advance with no run active returns a result with all fields zero.
// Throughput and path:
//   One item per cycle sustained while rsp_ready stays high. When the command queue
//   is empty, an accepted item passes through the front-end stages of source clip,
//   destination clip and row-times-stride multiply, then through the queue, before
//   the output register loads. The queue holds eight commands; req_ready drops once the
//   queue and front-end pipeline together hold that many.
// Reset and stalls:
//   Synchronous reset empties the pipeline and queue and ends any run. When the
//   receiver holds rsp_ready low the output register keeps its beat, the queue
//   fills, and req_ready falls; nothing is lost or repeated.
module clipped_blit_address_generator_unit import cbag_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   parameter int QDEPTH  = QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [dim_width(MAX_DIM)-1:0]     req_dest_width,
   input  logic [dim_width(MAX_DIM)-1:0]     req_dest_height,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_dest_x,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_dest_y,
   input  logic [dim_width(MAX_DIM)-1:0]     req_rect_width,
   input  logic [dim_width(MAX_DIM)-1:0]     req_rect_height,
   input  logic [dim_width(MAX_DIM)-1:0]     req_src_width,
   input  logic [dim_width(MAX_DIM)-1:0]     req_src_height,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_src_x,
   input  logic signed [dim_width(MAX_DIM)-1:0] req_src_y,
   input  logic                              req_dest_before_src,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pixel_valid,
   output logic [off_width(MAX_DIM)-1:0]     rsp_src_offset,
   output logic [off_width(MAX_DIM)-1:0]     rsp_dest_offset,
   output logic                              rsp_last,
   output logic                              rsp_empty_res,
   output logic [dim_width(MAX_DIM)-1:0]     rsp_clipped_width,
   output logic [dim_width(MAX_DIM)-1:0]     rsp_clipped_height
);

   localparam int CMDW = cmd_width(MAX_DIM);
   localparam int NW   = $clog2(QDEPTH + 1);

   logic            accept, push, q_pop, q_valid;
   logic [CMDW-1:0] push_data, q_data;
   logic [1:0]      inflight;
   logic [NW-1:0]   q_count;
   logic [NW:0]     committed;

   // hold off new beats while every queue slot is spoken for
   assign committed = (NW+1)'(q_count) + (NW+1)'(inflight);
   assign req_ready = committed < (NW+1)'(QDEPTH);
   assign accept    = req_valid && req_ready;

   cbag_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_kind            (req_kind),
      .req_dest_width      (req_dest_width),
      .req_dest_height     (req_dest_height),
      .req_dest_x          (req_dest_x),
      .req_dest_y          (req_dest_y),
      .req_rect_width      (req_rect_width),
      .req_rect_height     (req_rect_height),
      .req_src_width       (req_src_width),
      .req_src_height      (req_src_height),
      .req_src_x           (req_src_x),
      .req_src_y           (req_src_y),
      .req_dest_before_src (req_dest_before_src),
      .push                (push),
      .push_data           (push_data),
      .inflight            (inflight)
   );

   cbag_queue #(
      .DEPTH (QDEPTH),
      .WIDTH (CMDW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_data (q_data),
      .count     (q_count)
   );

   cbag_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_valid    (rsp_pixel_valid),
      .rsp_src_offset     (rsp_src_offset),
      .rsp_dest_offset    (rsp_dest_offset),
      .rsp_last           (rsp_last),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_clipped_width  (rsp_clipped_width),
      .rsp_clipped_height (rsp_clipped_height)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the clipped blit address generator unit.
module testbench;
   import cbag_pkg::*;

   localparam int DW           = dim_width(MAX_DIM_DEF);
   localparam int OW           = off_width(MAX_DIM_DEF);
   localparam int RANDOM_ITEMS = 1450;
   localparam int TAIL_ITEMS   = 150;
   localparam int MAX_RUN      = 48;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_CAP    = 50;

   typedef struct packed {
      kind_type      kind;
      logic [DW-1:0] dest_width;
      logic [DW-1:0] dest_height;
      logic [DW-1:0] dest_x;
      logic [DW-1:0] dest_y;
      logic [DW-1:0] rect_width;
      logic [DW-1:0] rect_height;
      logic [DW-1:0] src_width;
      logic [DW-1:0] src_height;
      logic [DW-1:0] src_x;
      logic [DW-1:0] src_y;
      logic          dest_before_src;
   } blit_cmd_type;

   typedef struct packed {
      logic          pixel_valid;
      logic [OW-1:0] src_offset;
      logic [OW-1:0] dest_offset;
      logic          last;
      logic          empty_res;
      logic [DW-1:0] clipped_width;
      logic [DW-1:0] clipped_height;
   } blit_res_type;

   typedef struct packed {
      int sx0, sy0, sx1, sy1, dx0, dy0, dx1, dy1;
   } clip_box_type;

   // typed = 1 means the row carries its own expected result
   typedef struct packed {
      blit_cmd_type cmd;
      bit           typed;
      blit_res_type res;
   } stim_row_type;

   localparam blit_res_type NO_PIXEL = '0;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_kind = 1'b0;
   logic [DW-1:0] req_dest_width = '0;
   logic [DW-1:0] req_dest_height = '0;
   logic signed [DW-1:0] req_dest_x = '0;
   logic signed [DW-1:0] req_dest_y = '0;
   logic [DW-1:0] req_rect_width = '0;
   logic [DW-1:0] req_rect_height = '0;
   logic [DW-1:0] req_src_width = '0;
   logic [DW-1:0] req_src_height = '0;
   logic signed [DW-1:0] req_src_x = '0;
   logic signed [DW-1:0] req_src_y = '0;
   logic          req_dest_before_src = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_pixel_valid;
   logic [OW-1:0] rsp_src_offset;
   logic [OW-1:0] rsp_dest_offset;
   logic          rsp_last;
   logic          rsp_empty_res;
   logic [DW-1:0] rsp_clipped_width;
   logic [DW-1:0] rsp_clipped_height;

   // predictor copy of the address engine state
   bit            run_on = 1'b0;
   bit            desc_order = 1'b0;
   logic [OW-1:0] src_row_base = '0;
   logic [OW-1:0] dst_row_base = '0;
   logic [DW-1:0] col_idx = '0;
   logic [DW-1:0] rows_remaining = '0;
   logic [DW-1:0] span_width = '0;
   logic [DW-1:0] src_pitch = '0;
   logic [DW-1:0] dst_pitch = '0;

   blit_res_type  blit_results_due[$];
   stim_row_type  typed_hints[$];
   int            mismatch_count = 0;
   int            result_index = 0;
   int            cycle_count = 0;
   int            gap_pct = 20;
   int            stall_pct = 20;
   int            stall_left = 0;
   bit            quiet_tail = 1'b0;

   clipped_blit_address_generator_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_dest_width      (req_dest_width),
      .req_dest_height     (req_dest_height),
      .req_dest_x          (req_dest_x),
      .req_dest_y          (req_dest_y),
      .req_rect_width      (req_rect_width),
      .req_rect_height     (req_rect_height),
      .req_src_width       (req_src_width),
      .req_src_height      (req_src_height),
      .req_src_x           (req_src_x),
      .req_src_y           (req_src_y),
      .req_dest_before_src (req_dest_before_src),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_valid     (rsp_pixel_valid),
      .rsp_src_offset      (rsp_src_offset),
      .rsp_dest_offset     (rsp_dest_offset),
      .rsp_last            (rsp_last),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_clipped_width   (rsp_clipped_width),
      .rsp_clipped_height  (rsp_clipped_height)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at cycle %0d, result %0d: %s", cycle_count, result_index, msg);
   endtask

   function automatic blit_res_type mk_res(input bit pv, input int so, input int dof,
                                           input bit lst, input bit emp, input int cw,
                                           input int ch);
      blit_res_type r;
      r.pixel_valid    = pv;
      r.src_offset     = so;
      r.dest_offset    = dof;
      r.last           = lst;
      r.empty_res      = emp;
      r.clipped_width  = cw;
      r.clipped_height = ch;
      return r;
   endfunction

   function automatic logic [OW-1:0] row_off(input int row, input int pitch, input int col);
      int p;
      p = row * pitch + col;
      return p[OW-1:0];
   endfunction

   // Clip to the source surface, then to the destination; each cut moves both corners.
   function automatic bit clip_window(input blit_cmd_type c, output clip_box_type b);
      int dw, dh, sw, sh, w, h;
      b  = '0;
      dw = c.dest_width;
      dh = c.dest_height;
      sw = c.src_width;
      sh = c.src_height;
      w  = c.rect_width;
      h  = c.rect_height;
      b.sx0 = signed'(c.src_x);
      b.sy0 = signed'(c.src_y);
      b.dx0 = signed'(c.dest_x);
      b.dy0 = signed'(c.dest_y);
      if (w == 0 || h == 0) return 1'b1;
      b.sx1 = b.sx0 + w - 1;
      b.sy1 = b.sy0 + h - 1;
      b.dx1 = b.dx0 + w - 1;
      b.dy1 = b.dy0 + h - 1;
      if (b.sx0 < 0) begin b.dx0 -= b.sx0; b.sx0 = 0; end
      if (b.sy0 < 0) begin b.dy0 -= b.sy0; b.sy0 = 0; end
      if (b.sx1 >= sw) begin b.dx1 -= b.sx1 - sw + 1; b.sx1 = sw - 1; end
      if (b.sy1 >= sh) begin b.dy1 -= b.sy1 - sh + 1; b.sy1 = sh - 1; end
      if (b.dx0 < 0) begin b.sx0 -= b.dx0; b.dx0 = 0; end
      if (b.dy0 < 0) begin b.sy0 -= b.dy0; b.dy0 = 0; end
      if (b.dx1 >= dw) begin b.sx1 -= b.dx1 - dw + 1; b.dx1 = dw - 1; end
      if (b.dy1 >= dh) begin b.sy1 -= b.dy1 - dh + 1; b.dy1 = dh - 1; end
      return b.sx1 < 0 || b.sx0 >= sw || b.sy1 < 0 || b.sy0 >= sh ||
             b.dx1 < 0 || b.dx0 >= dw || b.dy1 < 0 || b.dy0 >= dh ||
             b.sx1 < b.sx0 || b.sy1 < b.sy0;
   endfunction

   function automatic blit_res_type step_blit_engine(input blit_cmd_type c);
      blit_res_type r;
      clip_box_type b;
      bit row_end, fin;
      r = '0;
      if (c.kind == KIND_START) begin
         run_on = 1'b0;
         if (clip_window(c, b)) begin
            r.empty_res = 1'b1;
            return r;
         end
         span_width     = b.sx1 - b.sx0 + 1;
         rows_remaining = b.sy1 - b.sy0 + 1;
         src_pitch      = c.src_width;
         dst_pitch      = c.dest_width;
         desc_order     = !c.dest_before_src;
         col_idx        = '0;
         if (c.dest_before_src) begin
            src_row_base = row_off(b.sy0, src_pitch, b.sx0);
            dst_row_base = row_off(b.dy0, dst_pitch, b.dx0);
         end else begin
            // descending starts from the bottom-right corner
            src_row_base = row_off(b.sy1, src_pitch, b.sx1);
            dst_row_base = row_off(b.dy1, dst_pitch, b.dx1);
         end
         run_on           = 1'b1;
         r.clipped_width  = span_width;
         r.clipped_height = rows_remaining;
         return r;
      end
      if (!run_on) return r;
      r.pixel_valid = 1'b1;
      if (desc_order) begin
         r.src_offset  = src_row_base - col_idx;
         r.dest_offset = dst_row_base - col_idx;
      end else begin
         r.src_offset  = src_row_base + col_idx;
         r.dest_offset = dst_row_base + col_idx;
      end
      row_end = (int'(col_idx) + 1) >= int'(span_width);
      fin     = row_end && rows_remaining <= 1;
      r.last  = fin;
      if (fin) begin
         run_on         = 1'b0;
         col_idx        = '0;
         rows_remaining = '0;
      end else if (row_end) begin
         col_idx        = '0;
         rows_remaining = rows_remaining - 1'b1;
         if (desc_order) begin
            src_row_base = src_row_base - src_pitch;
            dst_row_base = dst_row_base - dst_pitch;
         end else begin
            src_row_base = src_row_base + src_pitch;
            dst_row_base = dst_row_base + dst_pitch;
         end
      end else begin
         col_idx = col_idx + 1'b1;
      end
      return r;
   endfunction

   function automatic blit_cmd_type noise_cmd();
      blit_cmd_type c;
      c.kind            = kind_type'($urandom_range(0, 1));
      c.dest_width      = $urandom;
      c.dest_height     = $urandom;
      c.dest_x          = $urandom;
      c.dest_y          = $urandom;
      c.rect_width      = $urandom;
      c.rect_height     = $urandom;
      c.src_width       = $urandom;
      c.src_height      = $urandom;
      c.src_x           = $urandom;
      c.src_y           = $urandom;
      c.dest_before_src = $urandom_range(0, 1);
      return c;
   endfunction

   function automatic blit_cmd_type advance_cmd();
      blit_cmd_type c;
      c      = noise_cmd();
      c.kind = KIND_ADVANCE;
      return c;
   endfunction

   function automatic blit_cmd_type start_cmd(input int dw, input int dh, input int dx,
                                              input int dy, input int rw, input int rh,
                                              input int sw, input int sh, input int sx,
                                              input int sy, input bit asc);
      blit_cmd_type c;
      c.kind            = KIND_START;
      c.dest_width      = dw;
      c.dest_height     = dh;
      c.dest_x          = dx;
      c.dest_y          = dy;
      c.rect_width      = rw;
      c.rect_height     = rh;
      c.src_width       = sw;
      c.src_height      = sh;
      c.src_x           = sx;
      c.src_y           = sy;
      c.dest_before_src = asc;
      return c;
   endfunction

   // corner near the near edge, near the far edge, or anywhere
   function automatic int edge_pos(input int extent);
      int pick;
      pick = $urandom_range(0, 2);
      if (pick == 0) return $urandom_range(0, 8) - 4;
      if (pick == 1) return extent - $urandom_range(0, 8);
      return $urandom_range(0, 8191) - 4096;
   endfunction

   function automatic int big_dim();
      return ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(1, 4096);
   endfunction

   function automatic blit_cmd_type rand_start();
      blit_cmd_type c;
      int pick;
      c      = noise_cmd();
      c.kind = KIND_START;
      pick   = $urandom_range(0, 99);
      if (pick < 72) begin
         c.src_width   = $urandom_range(1, 20);
         c.src_height  = $urandom_range(1, 20);
         c.dest_width  = $urandom_range(1, 20);
         c.dest_height = $urandom_range(1, 20);
         c.rect_width  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
         c.rect_height = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
         c.src_x       = $urandom_range(0, 28) - 6;
         c.src_y       = $urandom_range(0, 28) - 6;
         c.dest_x      = $urandom_range(0, 28) - 6;
         c.dest_y      = $urandom_range(0, 28) - 6;
      end else if (pick < 86) begin
         c.src_width   = big_dim();
         c.src_height  = big_dim();
         c.dest_width  = big_dim();
         c.dest_height = big_dim();
         c.rect_width  = $urandom_range(1, 6);
         c.rect_height = $urandom_range(1, 6);
         c.src_x       = edge_pos(c.src_width);
         c.src_y       = edge_pos(c.src_height);
         c.dest_x      = edge_pos(c.dest_width);
         c.dest_y      = edge_pos(c.dest_height);
      end else if (pick < 93) begin
         // surfaces past the nominal maximum; offsets wrap
         c.src_width   = $urandom_range(4097, 8191);
         c.src_height  = $urandom_range(4097, 8191);
         c.dest_width  = $urandom_range(4097, 8191);
         c.dest_height = $urandom_range(4097, 8191);
         c.rect_width  = $urandom_range(1, 5);
         c.rect_height = $urandom_range(1, 5);
      end
      return c;
   endfunction

   function automatic stim_row_type plan_row(input blit_cmd_type c, input bit typed,
                                             input blit_res_type r);
      stim_row_type s;
      s.cmd   = c;
      s.typed = typed;
      s.res   = r;
      return s;
   endfunction

   function automatic int pace_pick();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick < 2) return 0;
      return (pick == 2) ? 10 : 35;
   endfunction

   task automatic drive_item(input stim_row_type s);
      int n;
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
         n = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      typed_hints.push_back(s);
      req_valid           <= 1'b1;
      req_kind            <= s.cmd.kind;
      req_dest_width      <= s.cmd.dest_width;
      req_dest_height     <= s.cmd.dest_height;
      req_dest_x          <= s.cmd.dest_x;
      req_dest_y          <= s.cmd.dest_y;
      req_rect_width      <= s.cmd.rect_width;
      req_rect_height     <= s.cmd.rect_height;
      req_src_width       <= s.cmd.src_width;
      req_src_height      <= s.cmd.src_height;
      req_src_x           <= s.cmd.src_x;
      req_src_y           <= s.cmd.src_y;
      req_dest_before_src <= s.cmd.dest_before_src;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic check_result(input blit_res_type got);
      blit_res_type want;
      if (blit_results_due.size() == 0) begin
         report_mismatch("result beat with nothing outstanding");
         return;
      end
      want = blit_results_due.pop_front();
      if (got.pixel_valid !== want.pixel_valid)
         report_mismatch($sformatf("pixel_valid %0b, want %0b", got.pixel_valid,
                                   want.pixel_valid));
      if (got.src_offset !== want.src_offset)
         report_mismatch($sformatf("src_offset %0d, want %0d", got.src_offset,
                                   want.src_offset));
      if (got.dest_offset !== want.dest_offset)
         report_mismatch($sformatf("dest_offset %0d, want %0d", got.dest_offset,
                                   want.dest_offset));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      if (got.empty_res !== want.empty_res)
         report_mismatch($sformatf("empty_res %0b, want %0b", got.empty_res,
                                   want.empty_res));
      if (got.clipped_width !== want.clipped_width)
         report_mismatch($sformatf("clipped_width %0d, want %0d", got.clipped_width,
                                   want.clipped_width));
      if (got.clipped_height !== want.clipped_height)
         report_mismatch($sformatf("clipped_height %0d, want %0d", got.clipped_height,
                                   want.clipped_height));
   endtask

   always @(posedge clock) begin : accept_side
      blit_cmd_type c;
      blit_res_type p;
      stim_row_type h;
      if (!reset && req_valid && req_ready) begin
         c.kind            = kind_type'(req_kind);
         c.dest_width      = req_dest_width;
         c.dest_height     = req_dest_height;
         c.dest_x          = req_dest_x;
         c.dest_y          = req_dest_y;
         c.rect_width      = req_rect_width;
         c.rect_height     = req_rect_height;
         c.src_width       = req_src_width;
         c.src_height      = req_src_height;
         c.src_x           = req_src_x;
         c.src_y           = req_src_y;
         c.dest_before_src = req_dest_before_src;
         p = step_blit_engine(c);
         h = typed_hints.pop_front();
         blit_results_due.push_back(h.typed ? h.res : p);
      end
   end

   always @(posedge clock) begin : result_side
      blit_res_type g;
      if (!reset && rsp_valid && rsp_ready) begin
         g.pixel_valid    = rsp_pixel_valid;
         g.src_offset     = rsp_src_offset;
         g.dest_offset    = rsp_dest_offset;
         g.last           = rsp_last;
         g.empty_res      = rsp_empty_res;
         g.clipped_width  = rsp_clipped_width;
         g.clipped_height = rsp_clipped_height;
         check_result(g);
         result_index++;
      end
   end

   // hold ready low in bursts
   always @(posedge clock) begin : sink_pacing
      if (stall_left > 0) begin
         stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin : stimulus
      stim_row_type rows[$];
      clip_box_type box;
      blit_cmd_type c;
      blit_res_type empty_rect;
      int sent, run_len, n, pick, k;
      bit empty;
      empty_rect = mk_res(0, 0, 0, 0, 1, 0, 0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(plan_row(advance_cmd(), 1'b1, NO_PIXEL));
      rows.push_back(plan_row(start_cmd(16, 16, 0, 0, 0, 5, 16, 16, 0, 0, 1), 1'b1, empty_rect));
      rows.push_back(plan_row(start_cmd(16, 16, 0, 0, 5, 0, 16, 16, 0, 0, 0), 1'b1, empty_rect));
      // zero-size source, then zero-size destination
      rows.push_back(plan_row(start_cmd(16, 16, 0, 0, 4, 4, 0, 16, 0, 0, 1), 1'b1, empty_rect));
      rows.push_back(plan_row(start_cmd(16, 0, 0, 0, 4, 4, 16, 16, 0, 0, 1), 1'b1, empty_rect));
      rows.push_back(plan_row(start_cmd(8, 8, 2, 2, 2, 2, 8, 8, 1, 1, 1), 1'b1,
                              mk_res(0, 0, 0, 0, 0, 2, 2)));
      repeat (4) rows.push_back(plan_row(advance_cmd(), 1'b0, NO_PIXEL));
      rows.push_back(plan_row(advance_cmd(), 1'b1, NO_PIXEL));
      rows.push_back(plan_row(start_cmd(16, 16, 5, 4, 6, 4, 16, 16, -3, -2, 0), 1'b0,
                              NO_PIXEL));
      repeat (2) rows.push_back(plan_row(advance_cmd(), 1'b0, NO_PIXEL));
      // abandon the run with a single pixel at the far corner
      rows.push_back(plan_row(start_cmd(4096, 4096, 4095, 4095, 1, 1, 4096, 4096, 4095, 4095, 1),
                              1'b1, mk_res(0, 0, 0, 0, 0, 1, 1)));
      rows.push_back(plan_row(advance_cmd(), 1'b1,
                              mk_res(1, 24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0)));
      rows.push_back(plan_row(start_cmd(4096, 4096, -4096, -4096, 4096, 4096, 4096, 4096,
                                        -4096, -4096, 0), 1'b1, empty_rect));
      rows.push_back(plan_row(start_cmd(4096, 4096, 4095, 0, 4096, 3, 4096, 4096, 0, 0, 0),
                              1'b0, NO_PIXEL));
      repeat (3) rows.push_back(plan_row(advance_cmd(), 1'b0, NO_PIXEL));
      rows.push_back(plan_row(start_cmd(8191, 8191, 0, 0, 8191, 8191, 8191, 8191, 0, 0, 1),
                              1'b1, mk_res(0, 0, 0, 0, 0, 8191, 8191)));
      rows.push_back(plan_row(advance_cmd(), 1'b0, NO_PIXEL));
      // empty start drops the run in progress
      rows.push_back(plan_row(start_cmd(100, 100, 0, 0, 0, 0, 100, 100, 0, 0, 1), 1'b1,
                              empty_rect));
      rows.push_back(plan_row(advance_cmd(), 1'b1, NO_PIXEL));
      foreach (rows[i]) drive_item(rows[i]);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet_tail = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
         if ($urandom_range(0, 7) == 0) begin
            gap_pct   = pace_pick();
            stall_pct = pace_pick();
         end
         c       = rand_start();
         empty   = clip_window(c, box);
         run_len = empty ? 0 : (box.sx1 - box.sx0 + 1) * (box.sy1 - box.sy0 + 1);
         if (run_len > MAX_RUN) run_len = MAX_RUN;
         // mostly complete runs, some cut short, a few stray advances
         pick = $urandom_range(0, 99);
         if (pick < 70) n = run_len + $urandom_range(0, 1);
         else if (pick < 90) n = $urandom_range(0, run_len);
         else n = $urandom_range(0, 3);
         drive_item(plan_row(c, 1'b0, NO_PIXEL));
         sent++;
         for (k = 0; k < n; k++) begin
            drive_item(plan_row(advance_cmd(), 1'b0, NO_PIXEL));
            sent++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (blit_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (blit_results_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", blit_results_due.size()));
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
